### rtl/core/eoph_pkg.sv
// Package for the ellipse outline point and hit test block.
// Request/result payload types, field widths, codes and the CORDIC angle table.
// No dependencies.
package eoph_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned RAD_BITS    = COORD_BITS - 1;
  localparam int unsigned IDX_BITS    = 16;
  localparam int unsigned PREC_BITS   = 8;
  localparam int unsigned CNT_BITS    = 12;
  localparam int unsigned PHASE_BITS  = 32;
  localparam int unsigned TRIG_FRAC   = 30;
  localparam int unsigned CORD_W      = 33;
  localparam int unsigned ATAN_ENTRIES = 24;

  localparam logic [CORD_W-1:0] CORDIC_GAIN = 33'd652032874;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic {
    OP_OUTLINE = 1'b0,
    OP_TEST    = 1'b1
  } eoph_op_e;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_X = 2'd2,
    REG_RADIUS_Y = 2'd3
  } eoph_reg_e;

  typedef struct packed {
    logic                  operation;
    logic [IDX_BITS-1:0]   point_index;
    logic [PREC_BITS-1:0]  precision;
    logic [COORD_BITS-1:0] query_x;
    logic [COORD_BITS-1:0] query_y;
  } eoph_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  inside_res;
  } eoph_res_t;

endpackage

### rtl/core/ellipse_outline_point_and_hit_test.sv
// Ellipse outline point generator and point-in-ellipse tester, fully pipelined.
// Depends on eoph_pkg.
//
// Usage:
//  - Request channel in_valid_i / in_stall_o / in_req_i; result channel
//    out_valid_o / out_stall_i / out_res_o. A request moves on an edge with
//    valid high and stall low. Every request yields exactly one result, in order.
//  - Ellipse centre and radii are written through cfg_we_i / cfg_idx_i /
//    cfg_wdata_i while the block holds no request in flight.
//  - One request per cycle sustained while out_stall_i is low.
//  - Stages: capture, two modulo stages (8 remainder steps each), four phase
//    division stages (8 quotient bits each), CORDIC init, one CORDIC iteration
//    per stage, quadrant map, radius multiply, round and saturate into the output
//    register. The hit test runs alongside in the first stages with the request.
//  - Each stage holds its own valid bit and loads when it is empty or drains, so
//    bubbles close up while out_stall_i is high; the pipeline only stalls the
//    request side once every stage is full.
//  - Reset empties the pipeline and sets centre 0, radii 128.
module ellipse_outline_point_and_hit_test #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [23:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  eoph_pkg::eoph_req_t          in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output eoph_pkg::eoph_res_t          out_res_o
);
  import eoph_pkg::*;

  localparam int unsigned PW       = 2 * RAD_BITS;
  localparam int unsigned SQ       = 4 * RAD_BITS;
  localparam int unsigned DW       = COORD_BITS + 1;
  localparam int unsigned MW       = RAD_BITS + 1 + CORD_W;
  localparam int unsigned ST_DIFF  = 1;
  localparam int unsigned ST_BOX   = 2;
  localparam int unsigned ST_MUL   = 3;
  localparam int unsigned ST_SQ    = 4;
  localparam int unsigned ST_SUM   = 5;
  localparam int unsigned ST_CMP   = 6;
  localparam int unsigned ST_INIT  = 7;
  localparam int unsigned ST_CORD  = 8;
  localparam int unsigned ST_QUAD  = ST_CORD + CORDIC_STAGES;
  localparam int unsigned ST_SCALE = ST_QUAD + 1;
  localparam int unsigned ST_OUT   = ST_SCALE + 1;
  localparam int unsigned NS       = ST_OUT + 1;
  localparam int unsigned STEPS    = 8;

  typedef struct packed {
    logic                     op;
    logic [IDX_BITS-1:0]      idx;
    logic [CNT_BITS-1:0]      cnt;
    logic [CNT_BITS-1:0]      rem;
    logic [PHASE_BITS-1:0]    quo;
    logic [COORD_BITS-1:0]    qx;
    logic [COORD_BITS-1:0]    qy;
    logic [DW-1:0]            dx;
    logic [DW-1:0]            dy;
    logic [RAD_BITS-1:0]      adx;
    logic [RAD_BITS-1:0]      ady;
    logic                     hit_ok;
    logic [2:0][PW-1:0]       prd;
    logic [2:0][PW-1:0]       hh;
    logic [2:0][PW-1:0]       hl;
    logic [2:0][PW-1:0]       ll;
    logic [2:0][SQ-1:0]       sq;
    logic                     hit;
    logic [CORD_W-1:0]        cx;
    logic [CORD_W-1:0]        cy;
    logic [CORD_W-1:0]        cz;
    logic [1:0]               quad;
    logic [CORD_W-1:0]        tc;
    logic [CORD_W-1:0]        ts;
    logic [MW-1:0]            mx;
    logic [MW-1:0]            my;
    logic [COORD_BITS-1:0]    ox;
    logic [COORD_BITS-1:0]    oy;
  } pipe_t;

  logic [COORD_BITS-1:0] cfg_cx_q, cfg_cy_q;
  logic [RAD_BITS-1:0]   cfg_rx_q, cfg_ry_q;

  pipe_t           stg_d [NS];
  pipe_t           stg_q [NS];
  logic [NS-1:0]   vld_q;
  logic [NS:0]     rdy;

  function automatic logic [CNT_BITS-1:0] rem_step(input logic [CNT_BITS-1:0] r,
                                                   input logic b,
                                                   input logic [CNT_BITS-1:0] c);
    logic [CNT_BITS:0] r2;
    r2 = {r, b};
    if (r2 >= {1'b0, c}) begin
      r2 = r2 - {1'b0, c};
    end
    return r2[CNT_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [MW-1:0] v);
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    hi = MW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    lo = -hi - MW'(1);
    if ($signed(v) > hi) begin
      return hi[COORD_BITS-1:0];
    end else if ($signed(v) < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_q <= '0;
      cfg_cy_q <= '0;
      cfg_rx_q <= RAD_BITS'(128);
      cfg_ry_q <= RAD_BITS'(128);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cfg_cx_q <= cfg_wdata_i;
        REG_CENTER_Y: cfg_cy_q <= cfg_wdata_i;
        REG_RADIUS_X: cfg_rx_q <= cfg_wdata_i[RAD_BITS-1:0];
        REG_RADIUS_Y: cfg_ry_q <= cfg_wdata_i[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage logic
  for (genvar k = 0; k < NS; k++) begin : g_stg
    if (k == 0) begin : g_cap
      always_comb begin
        logic [PREC_BITS-1:0] prec;
        stg_d[k] = '0;
        prec = (in_req_i.precision == '0) ? PREC_BITS'(1) : in_req_i.precision;
        stg_d[k].op  = in_req_i.operation;
        stg_d[k].idx = in_req_i.point_index;
        stg_d[k].cnt = CNT_BITS'({prec, 3'b000}) + CNT_BITS'({prec, 2'b00});
        stg_d[k].qx  = in_req_i.query_x;
        stg_d[k].qy  = in_req_i.query_y;
      end
    end else if (k == ST_DIFF) begin : g_diff
      always_comb begin
        logic [CNT_BITS-1:0] r;
        stg_d[k] = stg_q[k-1];
        stg_d[k].dx = DW'($signed(stg_q[k-1].qx)) - DW'($signed(cfg_cx_q));
        stg_d[k].dy = DW'($signed(stg_q[k-1].qy)) - DW'($signed(cfg_cy_q));
        r = stg_q[k-1].rem;
        for (int j = 0; j < STEPS; j++) begin
          r = rem_step(r, stg_q[k-1].idx[IDX_BITS-1-j], stg_q[k-1].cnt);
        end
        stg_d[k].rem = r;
      end
    end else if (k == ST_BOX) begin : g_box
      always_comb begin
        logic [CNT_BITS-1:0] r;
        logic [DW-1:0]       ax;
        logic [DW-1:0]       ay;
        stg_d[k] = stg_q[k-1];
        ax = stg_q[k-1].dx[DW-1] ? -stg_q[k-1].dx : stg_q[k-1].dx;
        ay = stg_q[k-1].dy[DW-1] ? -stg_q[k-1].dy : stg_q[k-1].dy;
        stg_d[k].adx = ax[RAD_BITS-1:0];
        stg_d[k].ady = ay[RAD_BITS-1:0];
        stg_d[k].hit_ok = (ax <= DW'(cfg_rx_q)) && (ay <= DW'(cfg_ry_q)) &&
                          (cfg_rx_q != '0) && (cfg_ry_q != '0);
        r = stg_q[k-1].rem;
        for (int j = 0; j < STEPS; j++) begin
          r = rem_step(r, stg_q[k-1].idx[STEPS-1-j], stg_q[k-1].cnt);
        end
        stg_d[k].rem = r;
      end
    end else if (k >= ST_MUL && k <= ST_CMP) begin : g_div
      always_comb begin
        logic [CNT_BITS-1:0] r;
        logic [CNT_BITS:0]   r2;
        stg_d[k] = stg_q[k-1];
        r = stg_q[k-1].rem;
        for (int j = 0; j < STEPS; j++) begin
          r2 = {r, 1'b0};
          if (r2 >= {1'b0, stg_q[k-1].cnt}) begin
            r2 = r2 - {1'b0, stg_q[k-1].cnt};
            stg_d[k].quo[PHASE_BITS-1-(k-ST_MUL)*STEPS-j] = 1'b1;
          end else begin
            stg_d[k].quo[PHASE_BITS-1-(k-ST_MUL)*STEPS-j] = 1'b0;
          end
          r = r2[CNT_BITS-1:0];
        end
        stg_d[k].rem = r;
        if (k == ST_MUL) begin
          stg_d[k].prd[0] = stg_q[k-1].adx * cfg_ry_q;
          stg_d[k].prd[1] = stg_q[k-1].ady * cfg_rx_q;
          stg_d[k].prd[2] = cfg_rx_q * cfg_ry_q;
        end else if (k == ST_SQ) begin
          for (int j = 0; j < 3; j++) begin
            stg_d[k].hh[j] = stg_q[k-1].prd[j][PW-1:RAD_BITS] *
                             stg_q[k-1].prd[j][PW-1:RAD_BITS];
            stg_d[k].hl[j] = stg_q[k-1].prd[j][PW-1:RAD_BITS] *
                             stg_q[k-1].prd[j][RAD_BITS-1:0];
            stg_d[k].ll[j] = stg_q[k-1].prd[j][RAD_BITS-1:0] *
                             stg_q[k-1].prd[j][RAD_BITS-1:0];
          end
        end else if (k == ST_SUM) begin
          for (int j = 0; j < 3; j++) begin
            stg_d[k].sq[j] = {stg_q[k-1].hh[j], {PW{1'b0}}} +
                             (SQ'(stg_q[k-1].hl[j]) << (RAD_BITS + 1)) +
                             SQ'(stg_q[k-1].ll[j]);
          end
        end else begin
          stg_d[k].hit = (stg_q[k-1].op == OP_TEST) && stg_q[k-1].hit_ok &&
                         (({1'b0, stg_q[k-1].sq[0]} + {1'b0, stg_q[k-1].sq[1]}) <=
                          {1'b0, stg_q[k-1].sq[2]});
        end
      end
    end else if (k == ST_INIT) begin : g_init
      always_comb begin
        stg_d[k] = stg_q[k-1];
        stg_d[k].cx   = CORDIC_GAIN;
        stg_d[k].cy   = '0;
        stg_d[k].cz   = CORD_W'(stg_q[k-1].quo[PHASE_BITS-3:0]);
        stg_d[k].quad = stg_q[k-1].quo[PHASE_BITS-1:PHASE_BITS-2];
      end
    end else if (k >= ST_CORD && k < ST_QUAD) begin : g_cord
      always_comb begin
        logic [CORD_W-1:0] xs;
        logic [CORD_W-1:0] ys;
        logic [CORD_W-1:0] at;
        stg_d[k] = stg_q[k-1];
        xs = $signed(stg_q[k-1].cx) >>> (k - ST_CORD);
        ys = $signed(stg_q[k-1].cy) >>> (k - ST_CORD);
        at = CORD_W'(ATAN_TURNS[k-ST_CORD]);
        if (!stg_q[k-1].cz[CORD_W-1]) begin
          stg_d[k].cx = stg_q[k-1].cx - ys;
          stg_d[k].cy = stg_q[k-1].cy + xs;
          stg_d[k].cz = stg_q[k-1].cz - at;
        end else begin
          stg_d[k].cx = stg_q[k-1].cx + ys;
          stg_d[k].cy = stg_q[k-1].cy - xs;
          stg_d[k].cz = stg_q[k-1].cz + at;
        end
      end
    end else if (k == ST_QUAD) begin : g_quad
      always_comb begin
        stg_d[k] = stg_q[k-1];
        case (stg_q[k-1].quad)
          2'd0: begin
            stg_d[k].tc = stg_q[k-1].cx;
            stg_d[k].ts = stg_q[k-1].cy;
          end
          2'd1: begin
            stg_d[k].tc = -stg_q[k-1].cy;
            stg_d[k].ts = stg_q[k-1].cx;
          end
          2'd2: begin
            stg_d[k].tc = -stg_q[k-1].cx;
            stg_d[k].ts = -stg_q[k-1].cy;
          end
          default: begin
            stg_d[k].tc = stg_q[k-1].cy;
            stg_d[k].ts = -stg_q[k-1].cx;
          end
        endcase
      end
    end else if (k == ST_SCALE) begin : g_scale
      always_comb begin
        stg_d[k] = stg_q[k-1];
        stg_d[k].mx = $signed({1'b0, cfg_rx_q}) * $signed(stg_q[k-1].tc);
        stg_d[k].my = $signed({1'b0, cfg_ry_q}) * $signed(stg_q[k-1].ts);
      end
    end else begin : g_out
      always_comb begin
        logic [MW-1:0] rnd;
        logic [MW-1:0] ofx;
        logic [MW-1:0] ofy;
        stg_d[k] = stg_q[k-1];
        rnd = MW'(64'd1 << (TRIG_FRAC - 1));
        ofx = $signed(stg_q[k-1].mx + rnd) >>> TRIG_FRAC;
        ofy = $signed(stg_q[k-1].my + rnd) >>> TRIG_FRAC;
        if (stg_q[k-1].op == OP_TEST) begin
          stg_d[k].ox = '0;
          stg_d[k].oy = '0;
        end else begin
          stg_d[k].ox = sat_coord(MW'($signed(cfg_cx_q)) + ofx);
          stg_d[k].oy = sat_coord(MW'($signed(cfg_cy_q)) + ofy);
        end
      end
    end
  end

  // handshake: a stage loads when empty or when its contents move on
  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_stall_o           = !rdy[0];
  assign out_valid_o          = vld_q[ST_OUT];
  assign out_res_o.out_x      = stg_q[ST_OUT].ox;
  assign out_res_o.out_y      = stg_q[ST_OUT].oy;
  assign out_res_o.inside_res = stg_q[ST_OUT].hit;

  // checks
  a_outline_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stg_q[ST_OUT].op == OP_OUTLINE |-> !out_res_o.inside_res)
    else $error("outline result flagged inside");

  a_test_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stg_q[ST_OUT].op == OP_TEST |-> out_res_o.out_x == '0 &&
    out_res_o.out_y == '0)
    else $error("test result carries coordinates");

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("request stalled with result side free");

  a_mod_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_BOX] |-> stg_q[ST_BOX].rem < stg_q[ST_BOX].cnt)
    else $error("point index remainder out of range");

endmodule
